// ----- src/sha256_hash_engine_assert.svh -----
// assertion macros used by the sha-256 engine top level
`ifndef SHA256_HASH_ENGINE_ASSERT_SVH
`define SHA256_HASH_ENGINE_ASSERT_SVH

// same-cycle implication under the active-low reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha256 engine assertion failed");

// next-cycle implication under the active-low reset
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256 engine assertion failed");

`endif

// ----- src/sha256_pkg.sv -----
// shared types, constants and round functions of the sha-256 engine
`timescale 1ns / 1ps

package sha256_pkg;

    localparam logic [5:0]  ROUND_LAST  = 6'd63;
    localparam logic [3:0]  WIDX_LAST   = 4'd15;
    localparam logic [3:0]  WIDX_LEN_HI = 4'd14;
    localparam logic [2:0]  OIDX_LAST   = 3'd7;
    localparam logic [2:0]  BYTES_FULL  = 3'd4;
    localparam logic [31:0] PAD_WORD    = 32'h80000000;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_FINAL
    } sha256_core_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD_WORD,
        ST_PAD_ZERO,
        ST_OUT
    } sha256_state_t;

    typedef struct packed {
        logic        start;
        logic        init;
        logic        wr_en;
        logic [3:0]  wr_idx;
        logic [31:0] wr_data;
        logic [2:0]  rd_idx;
    } sha256_ctl_t;

    function automatic logic [31:0] sha256_iv(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sha256_k(input logic [5:0] i);
        logic [31:0] r;
        case (i)
            6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;
            default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sha256_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] sha256_sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic logic [31:0] sha256_sum0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] sha256_sum1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

endpackage

// ----- src/sha256_core.sv -----
// compression core: block window, one round per cycle, chaining value store
`timescale 1ns / 1ps

module sha256_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256_pkg::sha256_ctl_t ctl,
    output logic                   busy,
    output logic                   done,
    output logic [31:0]            rd_data
);

    sha256_pkg::sha256_core_state_t state_reg, state_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [31:0] win_reg [16];
    logic [31:0] h_reg   [8];
    logic [31:0] v_reg   [8];
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] choose;
    logic [31:0] major;

    // schedule word sixteen places ahead of the one used this round
    assign w_new = win_reg[0] + sha256_pkg::sha256_sig0(win_reg[1]) + win_reg[9]
                 + sha256_pkg::sha256_sig1(win_reg[14]);

    assign choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1 = v_reg[7] + sha256_pkg::sha256_sum1(v_reg[4]) + choose
              + sha256_pkg::sha256_k(rnd_reg) + win_reg[0];
    assign t2 = sha256_pkg::sha256_sum0(v_reg[0]) + major;

    assign busy    = (state_reg != sha256_pkg::CORE_IDLE);
    assign done    = (state_reg == sha256_pkg::CORE_FINAL);
    assign rd_data = h_reg[ctl.rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha256_pkg::CORE_IDLE;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        case (state_reg)
            sha256_pkg::CORE_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = sha256_pkg::CORE_ROUND;
                    rnd_next   = '0;
                end
            end
            sha256_pkg::CORE_ROUND:
            begin
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == sha256_pkg::ROUND_LAST)
                begin
                    state_next = sha256_pkg::CORE_FINAL;
                end
            end
            sha256_pkg::CORE_FINAL:
            begin
                state_next = sha256_pkg::CORE_IDLE;
            end
            default:
            begin
                state_next = sha256_pkg::CORE_IDLE;
            end
        endcase
    end

    // chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::sha256_iv(3'(i));
            end
        end
        else if (ctl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::sha256_iv(3'(i));
            end
        end
        else if (state_reg == sha256_pkg::CORE_FINAL)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    // working variables a to h
    always_ff @(posedge clk)
    begin
        if (state_reg == sha256_pkg::CORE_IDLE && ctl.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (state_reg == sha256_pkg::CORE_ROUND)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // block words are loaded in place, then shift through as the schedule window
    always_ff @(posedge clk)
    begin
        if (state_reg == sha256_pkg::CORE_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_new;
        end
        else if (ctl.wr_en)
        begin
            win_reg[ctl.wr_idx] <= ctl.wr_data;
        end
    end

endmodule

// ----- src/sha256_hash_engine.sv -----
// sha-256 engine top level: word intake, padding sequencer and digest output
// a non-last word is written into the block window; the sixteenth word of a block starts
// a compression (64 rounds, one chaining add) during which no item is taken
// a last word leads to a pad word, zero and length words and one or two compressions,
// then eight digest items leave the output register one per cycle as m_tready allows
// asynchronous active-low reset loads the initial hash and clears length and fill
`timescale 1ns / 1ps

`include "sha256_hash_engine_assert.svh"

module sha256_hash_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // data_word
    input  logic [2:0]  s_tuser,  // byte_count
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // digest_word
    output logic [2:0]  m_tuser,  // word_index
    output logic        m_tlast
);

    sha256_pkg::sha256_state_t state_reg, state_next;
    sha256_pkg::sha256_state_t ret_reg, ret_next;
    sha256_pkg::sha256_ctl_t   ctl;

    logic [3:0]  widx_reg, widx_next;
    logic [60:0] msg_reg, msg_next;
    logic        extra_reg, extra_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic [31:0] pend_reg, pend_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic [2:0]  m_tuser_reg, m_tuser_next;
    logic        m_tlast_reg, m_tlast_next;

    logic        core_busy;
    logic        core_done;
    logic [31:0] core_rd;
    logic        accept;
    logic        full_word;
    logic [31:0] part_word;
    logic [2:0]  count_eff;

    sha256_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .busy    (core_busy),
        .done    (core_done),
        .rd_data (core_rd)
    );

    assign s_tready = (state_reg == sha256_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // counts above four read as four
    assign full_word = (s_tuser >= sha256_pkg::BYTES_FULL);
    assign count_eff = full_word ? sha256_pkg::BYTES_FULL : s_tuser;

    // short last word: keep the valid upper bytes, marker byte right after them
    always_comb
    begin
        case (s_tuser)
            3'd0:    part_word = sha256_pkg::PAD_WORD;
            3'd1:    part_word = {s_tdata[31:24], sha256_pkg::PAD_WORD[31:8]};
            3'd2:    part_word = {s_tdata[31:16], sha256_pkg::PAD_WORD[31:16]};
            3'd3:    part_word = {s_tdata[31:8], sha256_pkg::PAD_WORD[31:24]};
            default: part_word = s_tdata;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha256_pkg::ST_IDLE;
            ret_reg      <= sha256_pkg::ST_IDLE;
            widx_reg     <= '0;
            msg_reg      <= '0;
            extra_reg    <= 1'b0;
            oidx_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            widx_reg     <= widx_next;
            msg_reg      <= msg_next;
            extra_reg    <= extra_next;
            oidx_reg     <= oidx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg    <= pend_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        widx_next     = widx_reg;
        msg_next      = msg_reg;
        extra_next    = extra_reg;
        oidx_next     = oidx_reg;
        pend_next     = pend_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        ctl           = '0;
        ctl.rd_idx    = oidx_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!s_tlast)
                    begin
                        ctl.wr_en   = 1'b1;
                        ctl.wr_idx  = widx_reg;
                        ctl.wr_data = s_tdata;
                        msg_next    = msg_reg + 61'(sha256_pkg::BYTES_FULL);
                        widx_next   = widx_reg + 4'd1;
                        if (widx_reg == sha256_pkg::WIDX_LAST)
                        begin
                            ctl.start  = 1'b1;
                            state_next = sha256_pkg::ST_COMP;
                            ret_next   = sha256_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        msg_next   = msg_reg + 61'(count_eff);
                        state_next = sha256_pkg::ST_PAD_WORD;
                        if (full_word)
                        begin
                            ctl.wr_en   = 1'b1;
                            ctl.wr_idx  = widx_reg;
                            ctl.wr_data = s_tdata;
                            widx_next   = widx_reg + 4'd1;
                            pend_next   = sha256_pkg::PAD_WORD;
                            if (widx_reg == sha256_pkg::WIDX_LAST)
                            begin
                                ctl.start  = 1'b1;
                                state_next = sha256_pkg::ST_COMP;
                                ret_next   = sha256_pkg::ST_PAD_WORD;
                            end
                        end
                        else
                        begin
                            pend_next = part_word;
                        end
                    end
                end
            end
            sha256_pkg::ST_PAD_WORD:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_idx  = widx_reg;
                ctl.wr_data = pend_reg;
                widx_next   = widx_reg + 4'd1;
                extra_next  = (widx_reg == sha256_pkg::WIDX_LEN_HI);
                state_next  = sha256_pkg::ST_PAD_ZERO;
                // marker word filled the block: length goes in a block of its own
                if (widx_reg == sha256_pkg::WIDX_LAST)
                begin
                    ctl.start  = 1'b1;
                    state_next = sha256_pkg::ST_COMP;
                    ret_next   = sha256_pkg::ST_PAD_ZERO;
                end
            end
            sha256_pkg::ST_PAD_ZERO:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_idx = widx_reg;
                widx_next  = widx_reg + 4'd1;
                if (extra_reg)
                begin
                    ctl.wr_data = '0;
                    if (widx_reg == sha256_pkg::WIDX_LAST)
                    begin
                        ctl.start  = 1'b1;
                        extra_next = 1'b0;
                        state_next = sha256_pkg::ST_COMP;
                        ret_next   = sha256_pkg::ST_PAD_ZERO;
                    end
                end
                else
                begin
                    // bit length is the byte count shifted up by three
                    if (widx_reg == sha256_pkg::WIDX_LEN_HI)
                    begin
                        ctl.wr_data = msg_reg[60:29];
                    end
                    else if (widx_reg == sha256_pkg::WIDX_LAST)
                    begin
                        ctl.wr_data = {msg_reg[28:0], 3'b000};
                    end
                    else
                    begin
                        ctl.wr_data = '0;
                    end
                    if (widx_reg == sha256_pkg::WIDX_LAST)
                    begin
                        ctl.start  = 1'b1;
                        state_next = sha256_pkg::ST_COMP;
                        ret_next   = sha256_pkg::ST_OUT;
                    end
                end
            end
            sha256_pkg::ST_COMP:
            begin
                if (core_done)
                begin
                    state_next = ret_reg;
                end
            end
            sha256_pkg::ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = core_rd;
                    m_tuser_next  = oidx_reg;
                    m_tlast_next  = (oidx_reg == sha256_pkg::OIDX_LAST);
                    oidx_next     = oidx_reg + 3'd1;
                    if (oidx_reg == sha256_pkg::OIDX_LAST)
                    begin
                        ctl.init   = 1'b1;
                        msg_next   = '0;
                        widx_next  = '0;
                        state_next = sha256_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase
    end

    `SHA_ASSERT_IMP(a_done_in_comp, clk, rst_n, core_done, state_reg == sha256_pkg::ST_COMP)
    `SHA_ASSERT_IMP(a_no_write_busy, clk, rst_n, ctl.wr_en, !core_busy)
    `SHA_ASSERT_NXT(a_start_busy, clk, rst_n, ctl.start, core_busy && state_reg == sha256_pkg::ST_COMP)
    `SHA_ASSERT_IMP(a_last_index, clk, rst_n, m_tvalid && m_tlast, m_tuser == sha256_pkg::OIDX_LAST)

endmodule
